// ===== rtl/pali_pkg.sv =====
// ----------------------------------------------------------------------------
// pali_pkg
// Shared types and constants of the polyline arc length interpolator.
// ----------------------------------------------------------------------------
package pali_pkg;

  localparam int DIST_W = 23;
  localparam int X_W    = 9;
  localparam int Y_W    = 8;
  localparam int IDX_W  = 6;
  localparam int NP_W   = 7;
  localparam int POS_W  = DIST_W + 1;
  localparam int DX_W   = X_W + 1;
  localparam int DY_W   = Y_W + 1;
  localparam int PROD_W = DX_W + POS_W;
  localparam int DEN_W  = DIST_W + 1;
  localparam int SUM_W  = PROD_W + 1;

  localparam logic            FUNC_LOAD  = 1'b0;
  localparam logic            FUNC_QUERY = 1'b1;
  localparam logic [NP_W-1:0] NP_RESET   = NP_W'(2);
  localparam logic [X_W-1:0]  X_SAT      = '1;
  localparam logic [Y_W-1:0]  Y_SAT      = '1;

  typedef struct packed {
    logic              func;
    logic [IDX_W-1:0]  point_index;
    logic [DIST_W-1:0] point_distance;
    logic [X_W-1:0]    point_x;
    logic [Y_W-1:0]    point_y;
    logic [DIST_W-1:0] travel_offset;
    logic [DIST_W-1:0] object_offset;
  } in_item_t;

  typedef struct packed {
    logic           on_path;
    logic [X_W-1:0] pos_x;
    logic [Y_W-1:0] pos_y;
  } out_item_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [X_W-1:0]    x;
    logic [Y_W-1:0]    y;
  } vertex_t;

  typedef enum logic [1:0] {
    RD_LAST,
    RD_ZERO,
    RD_NEXT
  } rd_sel_e;

  typedef enum logic [1:0] {
    RES_HOLD,
    RES_OFF,
    RES_PREV,
    RES_LERP
  } res_sel_e;

  typedef struct packed {
    logic     accept;
    rd_sel_e  rd_sel;
    logic     take_first;
    logic     scan_step;
    logic     take_curr;
    logic     mul;
    logic     div_start;
    res_sel_e res_sel;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic in_query;
    logic off_path;
    logic found;
    logic bottom_zero;
    logic div_done;
    logic out_busy;
  } sts_t;

endpackage

// ===== rtl/pali_stream_if.sv =====
// ----------------------------------------------------------------------------
// pali_stream_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface pali_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/pali_ram.sv =====
// ----------------------------------------------------------------------------
// pali_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module pali_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem_q [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/pali_div.sv =====
// ----------------------------------------------------------------------------
// pali_div
// Signed restoring divider, one quotient bit per cycle, truncates to zero.
// ----------------------------------------------------------------------------
module pali_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [pali_pkg::PROD_W-1:0] num_i,
  input  logic signed [pali_pkg::DEN_W-1:0]  den_i,
  output logic                               done_o,
  output logic signed [pali_pkg::PROD_W-1:0] quo_o
);
  import pali_pkg::*;

  localparam int CNT_W = $clog2(PROD_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PROD_W - 1);

  logic [PROD_W-1:0] n_q, n_d;
  logic [DEN_W-1:0]  r_q, r_d;
  logic [DEN_W-1:0]  d_q;
  logic              neg_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q, done_q;

  logic [DEN_W:0]    rs;
  logic [DEN_W:0]    diff;
  logic              ge;

  always_comb begin
    rs   = {r_q, n_q[PROD_W-1]};
    diff = rs - {1'b0, d_q};
    ge   = rs >= {1'b0, d_q};
    r_d  = ge ? diff[DEN_W-1:0] : rs[DEN_W-1:0];
    n_d  = {n_q[PROD_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      if (cnt_q == CNT_LAST) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= num_i[PROD_W-1] ? PROD_W'(-num_i) : PROD_W'(num_i);
      d_q   <= den_i[DEN_W-1] ? DEN_W'(-den_i) : DEN_W'(den_i);
      neg_q <= num_i[PROD_W-1] ^ den_i[DEN_W-1];
      r_q   <= '0;
    end else if (busy_q) begin
      n_q <= n_d;
      r_q <= r_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? $signed(-n_q) : $signed(n_q);

endmodule

// ===== rtl/pali_dpath.sv =====
// ----------------------------------------------------------------------------
// pali_dpath
// Vertex table, search registers, interpolation and result registers.
// ----------------------------------------------------------------------------
module pali_dpath #(
  parameter int MAX_POINTS = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  pali_pkg::cmd_t             cmd_i,
  output pali_pkg::sts_t             sts_o,
  input  pali_pkg::in_item_t         in_data_i,
  input  logic                       cfg_we_i,
  input  logic [pali_pkg::NP_W-1:0]  cfg_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output pali_pkg::out_item_t        out_data_o
);
  import pali_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);

  logic [NP_W-1:0]         num_points_q;
  logic [AW-1:0]           last_idx;
  logic [AW-1:0]           cursor_q;
  logic [AW-1:0]           raddr;
  logic                    ram_we;
  vertex_t                 wr_vtx, rd_vtx;

  logic signed [POS_W-1:0] pos_d, pos_q;
  vertex_t                 prev_q, curr_q;
  logic signed [DX_W-1:0]  dx;
  logic signed [DY_W-1:0]  dy;
  logic signed [POS_W-1:0] top;
  logic signed [DEN_W-1:0] bottom, den_q;
  logic signed [PROD_W-1:0] prod_x_d, prod_y_d, prod_x_q, prod_y_q;
  logic signed [PROD_W-1:0] quo_x, quo_y;
  logic                    done_x, done_y;
  logic signed [SUM_W-1:0] sum_x, sum_y;
  logic [X_W-1:0]          sat_x, sat_y;

  out_item_t               res_q, out_q;
  logic                    out_valid_q;

  function automatic logic [X_W-1:0] sat_lerp(input logic signed [SUM_W-1:0] v,
                                               input logic [X_W-1:0] maxv);
    logic [X_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed({{(SUM_W-X_W){1'b0}}, maxv})) begin
      r = maxv;
    end else begin
      r = v[X_W-1:0];
    end
    return r;
  endfunction

  // clamp of the vertex count to 2 .. MAX_POINTS
  always_comb begin
    if (num_points_q < NP_W'(2)) begin
      last_idx = AW'(1);
    end else if (32'(num_points_q) > MAX_POINTS) begin
      last_idx = AW'(MAX_POINTS - 1);
    end else begin
      last_idx = AW'(num_points_q - NP_W'(1));
    end
  end

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_ZERO: raddr = '0;
      RD_NEXT: raddr = cursor_q + AW'(1);
      default: raddr = last_idx;
    endcase
  end

  assign ram_we = cmd_i.accept && (in_data_i.func == FUNC_LOAD) &&
                  (32'(in_data_i.point_index) < MAX_POINTS);
  assign wr_vtx = '{distance: in_data_i.point_distance, x: in_data_i.point_x,
                    y: in_data_i.point_y};

  pali_ram #(
    .W ($bits(vertex_t)),
    .D (MAX_POINTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(in_data_i.point_index)),
    .wdata_i (wr_vtx),
    .raddr_i (raddr),
    .rdata_o (rd_vtx)
  );

  assign pos_d = $signed({1'b0, in_data_i.travel_offset}) -
                 $signed({1'b0, in_data_i.object_offset});

  always_comb begin
    dx       = $signed({1'b0, curr_q.x}) - $signed({1'b0, prev_q.x});
    dy       = $signed({1'b0, curr_q.y}) - $signed({1'b0, prev_q.y});
    top      = pos_q - $signed({1'b0, prev_q.distance});
    bottom   = $signed({1'b0, curr_q.distance}) - $signed({1'b0, prev_q.distance});
    prod_x_d = dx * top;
    prod_y_d = dy * top;
  end

  pali_div u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (prod_x_q),
    .den_i   (den_q),
    .done_o  (done_x),
    .quo_o   (quo_x)
  );

  pali_div u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (prod_y_q),
    .den_i   (den_q),
    .done_o  (done_y),
    .quo_o   (quo_y)
  );

  always_comb begin
    sum_x = $signed({{(SUM_W-X_W){1'b0}}, prev_q.x}) + $signed({quo_x[PROD_W-1], quo_x});
    sum_y = $signed({{(SUM_W-Y_W){1'b0}}, prev_q.y}) + $signed({quo_y[PROD_W-1], quo_y});
    sat_x = sat_lerp(sum_x, X_SAT);
    sat_y = sat_lerp(sum_y, {1'b0, Y_SAT});
  end

  always_comb begin
    sts_o.in_query    = in_data_i.func == FUNC_QUERY;
    sts_o.off_path    = pos_q[POS_W-1] || (pos_q[DIST_W-1:0] > rd_vtx.distance);
    sts_o.found       = (cursor_q == last_idx) || !(rd_vtx.distance < pos_q[DIST_W-1:0]);
    sts_o.bottom_zero = curr_q.distance == prev_q.distance;
    sts_o.div_done    = done_x & done_y;
    sts_o.out_busy    = out_valid_q & ~out_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_points_q <= NP_RESET;
      cursor_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        num_points_q <= cfg_data_i;
      end
      if (cmd_i.accept) begin
        cursor_q <= '0;
      end else if (cmd_i.take_first) begin
        cursor_q <= AW'(1);
      end else if (cmd_i.scan_step) begin
        cursor_q <= cursor_q + AW'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pos_q <= pos_d;
    end
    if (cmd_i.take_first || cmd_i.scan_step) begin
      prev_q <= rd_vtx;
    end
    if (cmd_i.take_curr) begin
      curr_q <= rd_vtx;
    end
    if (cmd_i.mul) begin
      prod_x_q <= prod_x_d;
      prod_y_q <= prod_y_d;
      den_q    <= bottom;
    end
    unique case (cmd_i.res_sel)
      RES_OFF:  res_q <= '{on_path: 1'b0, pos_x: '0, pos_y: '0};
      RES_PREV: res_q <= '{on_path: 1'b1, pos_x: prev_q.x, pos_y: prev_q.y};
      RES_LERP: res_q <= '{on_path: 1'b1, pos_x: sat_x, pos_y: sat_y[Y_W-1:0]};
      default:  res_q <= res_q;
    endcase
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/pali_ctrl.sv =====
// ----------------------------------------------------------------------------
// pali_ctrl
// Sequencer for load and query beats: range check, scan, divide, deliver.
// ----------------------------------------------------------------------------
module pali_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  pali_pkg::sts_t sts_i,
  output pali_pkg::cmd_t cmd_o
);
  import pali_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CHK   = 8'b0000_0010,
    S_GET0  = 8'b0000_0100,
    S_SCAN  = 8'b0000_1000,
    S_MUL   = 8'b0001_0000,
    S_DIVGO = 8'b0010_0000,
    S_DIV   = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '{accept: 1'b0, rd_sel: RD_LAST, take_first: 1'b0, scan_step: 1'b0,
                   take_curr: 1'b0, mul: 1'b0, div_start: 1'b0, res_sel: RES_HOLD,
                   out_load: 1'b0};
    unique case (state_q)
      S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && sts_i.in_query) begin
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        cmd_o.rd_sel = RD_ZERO;
        if (sts_i.off_path) begin
          cmd_o.res_sel = RES_OFF;
          state_d       = S_FIN;
        end else begin
          state_d = S_GET0;
        end
      end
      S_GET0: begin
        cmd_o.rd_sel     = RD_NEXT;
        cmd_o.take_first = 1'b1;
        state_d          = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.rd_sel = RD_NEXT;
        if (sts_i.found) begin
          cmd_o.take_curr = 1'b1;
          state_d         = S_MUL;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_MUL: begin
        if (sts_i.bottom_zero) begin
          cmd_o.res_sel = RES_PREV;
          state_d       = S_FIN;
        end else begin
          cmd_o.mul = 1'b1;
          state_d   = S_DIVGO;
        end
      end
      S_DIVGO: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV;
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.res_sel = RES_LERP;
          state_d       = S_FIN;
        end
      end
      S_FIN: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/polyline_arc_length_interpolator_unit.sv =====
// ----------------------------------------------------------------------------
// polyline_arc_length_interpolator_unit
// Point on a polyline at a given arc length, by linear interpolation.
// ----------------------------------------------------------------------------
// Load beat: written straight into the vertex RAM; the unit stays ready for the next beat.
// Query beat: the result follows the range check when off the path; otherwise
// one RAM read per vertex up to the vertex i found (1 .. num_points-1), then the
// divider, which is skipped when vertices i-1 and i share a distance.
// One query in flight; the next beat is taken while the result waits.
// Reset: num_points = 2, no result pending; the vertex RAM is not cleared.
module polyline_arc_length_interpolator_unit #(
  parameter int MAX_POINTS = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  pali_stream_if.sink   in_i,
  pali_stream_if.source out_o,
  pali_stream_if.sink   cfg_i
);
  import pali_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  pali_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pali_dpath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_i.data),
    .cfg_we_i    (cfg_i.valid),
    .cfg_data_i  (cfg_i.data),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_o.data)
  );

  assign in_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;

  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready && (in_i.data.func == FUNC_LOAD) && !out_o.valid
    |=> !out_o.valid)
    else $error("load beat produced a result");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready && (in_i.data.func == FUNC_QUERY) |=> !in_i.ready)
    else $error("input taken while a query is in work");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> !$past(in_i.ready))
    else $error("result raised without a query in work");

endmodule
